// File: src/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
// No dependencies; used by every module of the block by scoped names.
package slfd_pkg;

  // Deframer phase codes.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Configuration register indexes.
  localparam logic CFG_SYNC_PATTERN = 1'b0;
  localparam logic CFG_MAX_LENGTH   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] SYNC_PATTERN_RESET = 32'h3330_3032;
  localparam logic [30:0] MAX_LENGTH_RESET   = 31'd104857600;

  // Number of length bytes in a header.
  localparam int unsigned LEN_BYTES = 4;

  // One result item.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       empty_frame;
  } result_t;

  // Deframer status seen by the top level.
  typedef struct packed {
    phase_t     phase;
    logic [1:0] count;
  } status_t;

endpackage

// File: src/slfd_fsm.sv
// Deframer state machine: sync hunt, length gathering and payload pass-through.
// Depends on slfd_pkg for the phase enum and the result and status structs.
module slfd_fsm #(
  parameter int unsigned SYNC_LEN = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        sync_pattern,
  input  logic [30:0]        max_frame_length,
  output logic               res_valid,
  output slfd_pkg::result_t  res,
  output slfd_pkg::status_t  status
);

  slfd_pkg::phase_t phase, phase_next;
  logic [1:0]  count, count_next;
  logic [23:0] length_low, length_low_next;
  logic [30:0] remaining, remaining_next;

  logic [7:0]  expected;
  logic        sync_hit;
  logic        first_hit;
  logic [2:0]  hunt_count;
  logic [30:0] frame_length;
  logic        bad_length;

  // Control state register; cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= slfd_pkg::PH_HUNT;
      count     <= 2'd0;
      remaining <= 31'd0;
    end else if (step) begin
      phase     <= phase_next;
      count     <= count_next;
      remaining <= remaining_next;
    end
  end

  // Low length bytes; each is written once per header before it is read.
  always_ff @(posedge clk) begin
    if (step) begin
      length_low <= length_low_next;
    end
  end

  // Sync compare for the byte at hand.
  assign expected   = sync_pattern[{count, 3'b000} +: 8];
  assign sync_hit   = (data_byte == expected);
  assign first_hit  = (data_byte == sync_pattern[7:0]);
  assign hunt_count = sync_hit ? ({1'b0, count} + 3'd1) : {2'b00, first_hit};

  // Full length once the last length byte arrives.
  assign frame_length = {data_byte[6:0], length_low};
  assign bad_length   = data_byte[7] || (frame_length >= max_frame_length);

  // Next state and result for one transaction.
  always_comb begin
    phase_next      = phase;
    count_next      = count;
    length_low_next = length_low;
    remaining_next  = remaining;
    res_valid       = 1'b0;
    res             = '0;
    unique case (phase)
      slfd_pkg::PH_LENGTH: begin
        if (count == 2'(slfd_pkg::LEN_BYTES - 1)) begin
          count_next = 2'd0;
          phase_next = slfd_pkg::PH_HUNT;
          if (!bad_length) begin
            if (frame_length == 31'd0) begin
              res_valid       = 1'b1;
              res.frame_end   = 1'b1;
              res.empty_frame = 1'b1;
            end else begin
              remaining_next = frame_length;
              phase_next     = slfd_pkg::PH_PAYLOAD;
            end
          end
        end else begin
          length_low_next[{count, 3'b000} +: 8] = data_byte;
          count_next = count + 2'd1;
        end
      end
      slfd_pkg::PH_PAYLOAD: begin
        remaining_next   = remaining - 31'd1;
        res_valid        = 1'b1;
        res.payload_byte = data_byte;
        res.frame_end    = (remaining == 31'd1);
        if (remaining == 31'd1) begin
          phase_next = slfd_pkg::PH_HUNT;
        end
      end
      default: begin
        // Hunting: a full match moves on to the length bytes.
        if (hunt_count == 3'(SYNC_LEN)) begin
          phase_next = slfd_pkg::PH_LENGTH;
          count_next = 2'd0;
        end else begin
          phase_next = slfd_pkg::PH_HUNT;
          count_next = hunt_count[1:0];
        end
      end
    endcase
  end

  assign status.phase = phase;
  assign status.count = count;

endmodule

// File: src/slfd_out_stage.sv
// Output register of the deframer: holds one result until it is taken.
// Depends on slfd_pkg for the result struct.
module slfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slfd_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              free,
  output slfd_pkg::result_t held
);

  // The stage can take a new result when empty or when its result leaves now.
  assign free = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// File: src/sync_length_frame_deframer.sv
// Top level of the sync-word, length-prefixed frame deframer.
// Depends on slfd_pkg, slfd_fsm and slfd_out_stage.
//
//   Channel  Signals                                  Direction
//   input    in_valid, in_ready, data_byte            into block
//   output   out_valid, out_ready, payload_byte,      out of block
//            frame_end, empty_frame
//   config   cfg_we, cfg_index, cfg_data              into block
//
// One byte is accepted per cycle unless stalled; its result, if any, appears
// in the output register in the next cycle. The state update and the result
// come from a single pass of logic between the byte and the output register.
// Reset is synchronous and returns the block to the sync hunt with default
// configuration. While a result is held and out_ready is low, in_ready is low.
module sync_length_frame_deframer #(
  parameter int unsigned SYNC_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        frame_end,
  output logic        empty_frame,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]       sync_pattern;
  logic [30:0]       max_frame_length;
  logic              step;
  logic              res_valid;
  slfd_pkg::result_t res;
  slfd_pkg::result_t held;
  slfd_pkg::status_t status;
  logic              free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern     <= slfd_pkg::SYNC_PATTERN_RESET;
      max_frame_length <= slfd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slfd_pkg::CFG_SYNC_PATTERN: sync_pattern     <= cfg_data;
        slfd_pkg::CFG_MAX_LENGTH:   max_frame_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign in_ready = free;
  assign step     = in_valid && in_ready;

  slfd_fsm #(
    .SYNC_LEN(SYNC_LEN)
  ) u_fsm (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (data_byte),
    .sync_pattern    (sync_pattern),
    .max_frame_length(max_frame_length),
    .res_valid       (res_valid),
    .res             (res),
    .status          (status)
  );

  slfd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .res      (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .free     (free),
    .held     (held)
  );

  assign payload_byte = held.payload_byte;
  assign frame_end    = held.frame_end;
  assign empty_frame  = held.empty_frame;

  // A payload byte accepted always produces a result in the next cycle.
  a_payload_gives_result: assert property (@(posedge clk) disable iff (rst)
    (step && status.phase == slfd_pkg::PH_PAYLOAD) |=> out_valid)
    else $error("payload byte did not produce a result");

  // An empty frame result is a frame end with a zero byte.
  a_empty_frame_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_frame) |-> (frame_end && payload_byte == 8'd0))
    else $error("malformed empty frame result");

  // A held frame end means the deframer has gone back to hunting.
  a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (status.phase == slfd_pkg::PH_HUNT))
    else $error("frame ended but deframer not hunting");

  // A held byte that is not the last one means the frame is still open.
  a_mid_frame_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (status.phase == slfd_pkg::PH_PAYLOAD))
    else $error("mid-frame byte held outside the payload phase");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for sync_length_frame_deframer: byte driver, result monitor and
// a byte-level deframing predictor fed from the accepted byte transactions.
// Depends on slfd_pkg and the sync_length_frame_deframer RTL.
module tb_top;

  localparam int unsigned SYNC_LEN = 4;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic        empty_frame;
  logic        cfg_we = 1'b0;
  logic        cfg_index = slfd_pkg::CFG_SYNC_PATTERN;
  logic [31:0] cfg_data = 32'h0;

  // Bench copy of the configuration registers.
  logic [31:0] sync_word = slfd_pkg::SYNC_PATTERN_RESET;
  logic [30:0] max_length = slfd_pkg::MAX_LENGTH_RESET;

  // Predicted deframer state.
  slfd_pkg::phase_t df_phase = slfd_pkg::PH_HUNT;
  logic [2:0]  df_count = 3'd0;
  logic [31:0] df_length = 32'h0;
  logic [30:0] df_remaining = 31'h0;

  logic [7:0]        pending_bytes[$];
  slfd_pkg::result_t expected_results[$];
  slfd_pkg::result_t oldest_result;
  logic        byte_taken = 1'b0;
  int          sender_gap_pct = 27;
  int          receiver_stall_pct = 45;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  int          n_errors = 0;

  sync_length_frame_deframer #(.SYNC_LEN(SYNC_LEN)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .payload_byte(payload_byte),
    .frame_end   (frame_end),
    .empty_frame (empty_frame),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted deframer by one received byte and queue any result it gives.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0] len;
    slfd_pkg::result_t r;
    if (df_phase == slfd_pkg::PH_LENGTH) begin
      df_length = df_length | (32'(b) << (df_count[1:0] * 8));
      df_count = df_count + 3'd1;
      if (df_count >= 3'(slfd_pkg::LEN_BYTES)) begin
        len = df_length;
        df_count = 3'd0;
        df_length = 32'h0;
        df_phase = slfd_pkg::PH_HUNT;
        // Negative or oversized lengths drop the header silently.
        if (!len[31] && len < {1'b0, max_length}) begin
          if (len == 32'h0) begin
            r.payload_byte = 8'h00;
            r.frame_end = 1'b1;
            r.empty_frame = 1'b1;
            expected_results = {expected_results, r};
          end else begin
            df_remaining = len[30:0];
            df_phase = slfd_pkg::PH_PAYLOAD;
          end
        end
      end
    end else if (df_phase == slfd_pkg::PH_PAYLOAD) begin
      if (df_remaining != 31'h0) df_remaining = df_remaining - 31'd1;
      r.payload_byte = b;
      r.frame_end = (df_remaining == 31'h0);
      r.empty_frame = 1'b0;
      expected_results = {expected_results, r};
      if (df_remaining == 31'h0) df_phase = slfd_pkg::PH_HUNT;
    end else begin
      // Sync hunt; an unused phase code falls back to a fresh hunt.
      if (df_phase != slfd_pkg::PH_HUNT) begin
        df_phase = slfd_pkg::PH_HUNT;
        df_count = 3'd0;
      end
      if (df_count >= 3'(SYNC_LEN)) df_count = 3'd0;
      if (b == sync_word[df_count[1:0] * 8 +: 8]) begin
        df_count = df_count + 3'd1;
      end else begin
        // A mismatching byte is retried as the first sync byte.
        df_count = (b == sync_word[7:0]) ? 3'd1 : 3'd0;
      end
      if (df_count >= 3'(SYNC_LEN)) begin
        df_phase = slfd_pkg::PH_LENGTH;
        df_count = 3'd0;
        df_length = 32'h0;
      end
    end
  endfunction

  // Queue a full header with the given length field, then n_payload random bytes.
  function automatic void push_frame(input logic [31:0] length_field, input int n_payload);
    for (int k = 0; k < SYNC_LEN; k++) pending_bytes = {pending_bytes, sync_word[k * 8 +: 8]};
    for (int k = 0; k < slfd_pkg::LEN_BYTES; k++) begin
      pending_bytes = {pending_bytes, length_field[k * 8 +: 8]};
    end
    repeat (n_payload) pending_bytes = {pending_bytes, 8'($urandom)};
  endfunction

  // Sync pattern whose first byte occurs only once, so leftover hunt state never
  // shifts the next frame out of alignment.
  function automatic logic [31:0] unique_head_pattern();
    logic [31:0] p;
    do begin
      p = $urandom;
    end while (p[7:0] == p[15:8] || p[7:0] == p[23:16] || p[7:0] == p[31:24]);
    return p;
  endfunction

  // Mostly well-formed frames with random content; the rest are rejected lengths,
  // broken sync prefixes and loose noise bytes.
  function automatic void queue_random_stream(input int n_bytes, input bit with_noise);
    int start;
    int pick;
    int cap;
    int len_hi;
    int n;
    logic [31:0] len;
    logic [7:0] b;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_bytes) begin
      pick = with_noise ? $urandom_range(0, 99) : $urandom_range(0, 79);
      if (pick < 65 && max_length != 31'h0) begin
        cap = ($urandom_range(0, 15) == 0) ? 200 : 24;
        len_hi = (max_length <= 31'(cap)) ? int'(max_length) - 1 : cap;
        len = ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom_range(0, len_hi));
        push_frame(len, int'(len));
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0, 1: len = {1'b1, 31'($urandom)};
          2: len = {1'b0, max_length};
          default: len = {1'b0, max_length} + ($urandom % (32'h8000_0000 - max_length));
        endcase
        push_frame(len, 0);
      end else if (pick < 92) begin
        n = $urandom_range(1, SYNC_LEN - 1);
        for (int k = 0; k < n; k++) pending_bytes = {pending_bytes, sync_word[k * 8 +: 8]};
        b = $urandom_range(0, 1) ? sync_word[7:0] : 8'($urandom);
        if (b == sync_word[n * 8 +: 8]) b = b ^ 8'h01;
        pending_bytes = {pending_bytes, b};
      end else begin
        repeat ($urandom_range(1, 6)) pending_bytes = {pending_bytes, 8'($urandom)};
      end
    end
  endfunction

  // Register write; the bench copy follows at the edge that performs it.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == slfd_pkg::CFG_SYNC_PATTERN) sync_word = value;
    else max_length = value[30:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every byte is taken and every predicted result has been seen,
  // then give the result register time to settle.
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Byte driver: offer the next queued byte once the previous transaction is done.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        in_valid <= 1'b1;
        data_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input transactions feed the predictor.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      byte_taken = 1'b1;
      deframe_byte(data_byte);
    end
  end

  // Receiver: random stalls, plus one long hold-off when neither side idles.
  always @(negedge clk) begin
    if (sender_gap_pct == 0 && receiver_stall_pct == 0 && hold_cycles < LONG_HOLD) begin
      hold_cycles <= hold_cycles + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Monitor: each output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %02h end %0b empty %0b",
                 $time, payload_byte, frame_end, empty_frame);
        n_errors++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (payload_byte !== oldest_result.payload_byte) begin
          $display("%0t: payload_byte mismatch: expected %02h, actual %02h",
                   $time, oldest_result.payload_byte, payload_byte);
          n_errors++;
        end
        if (frame_end !== oldest_result.frame_end) begin
          $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                   $time, oldest_result.frame_end, frame_end);
          n_errors++;
        end
        if (empty_frame !== oldest_result.empty_frame) begin
          $display("%0t: empty_frame mismatch: expected %0b, actual %0b",
                   $time, oldest_result.empty_frame, empty_frame);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sync_length_frame_deframer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: a partial sync whose breaking byte restarts the hunt, an empty
    // frame, a one-byte frame and a negative length.
    pending_bytes = {pending_bytes, sync_word[7:0]};
    pending_bytes = {pending_bytes, sync_word[15:8]};
    push_frame(32'h0, 0);
    push_frame(32'h1, 1);
    push_frame(32'hFFFF_FFFF, 0);
    queue_random_stream(500, 1'b1);
    wait_until_drained();

    // All-zero sync and the smallest nonzero limit: only empty frames pass.
    write_reg(slfd_pkg::CFG_SYNC_PATTERN, 32'h0000_0000);
    write_reg(slfd_pkg::CFG_MAX_LENGTH, {1'($urandom_range(0, 1)), 31'd1});
    queue_random_stream(150, 1'b0);
    wait_until_drained();

    // Swap the idle pattern; all-ones sync and the largest limit.
    sender_gap_pct = 45;
    receiver_stall_pct = 27;
    write_reg(slfd_pkg::CFG_SYNC_PATTERN, 32'hFFFF_FFFF);
    write_reg(slfd_pkg::CFG_MAX_LENGTH, {1'($urandom_range(0, 1)), 31'h7FFF_FFFF});
    queue_random_stream(200, 1'b0);
    wait_until_drained();

    // Small limit with the length just below and at the boundary.
    write_reg(slfd_pkg::CFG_SYNC_PATTERN, unique_head_pattern());
    write_reg(slfd_pkg::CFG_MAX_LENGTH, {1'($urandom_range(0, 1)), 31'd17});
    push_frame(32'd16, 16);
    push_frame(32'd17, 0);
    queue_random_stream(400, 1'b1);
    wait_until_drained();

    // Zero limit rejects every length.
    write_reg(slfd_pkg::CFG_MAX_LENGTH, {1'($urandom_range(0, 1)), 31'd0});
    queue_random_stream(80, 1'b0);
    wait_until_drained();

    // Back to the default limit with no idling; the receiver holds off first.
    write_reg(slfd_pkg::CFG_SYNC_PATTERN, unique_head_pattern());
    write_reg(slfd_pkg::CFG_MAX_LENGTH,
              {1'($urandom_range(0, 1)), slfd_pkg::MAX_LENGTH_RESET});
    queue_random_stream(600, 1'b1);
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    wait_until_drained();

    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("sync_length_frame_deframer verification clean");
    end else begin
      $display("sync_length_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
